@@ src/tklt_pkg.sv @@
package tklt_pkg;

    localparam int SIZE_W = 64;
    localparam int CNT_W  = 5;
    localparam int RANK_W = 4;
    localparam int OTAG_W = 32;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // per-cell control; ins_en is shared by every cell of the chain
    typedef struct packed {
        logic ins_en;   // an insert lands somewhere in the list this cycle
        logic valid;    // cell holds a live entry
        logic prev_ge;  // upstream neighbor keeps its entry
    } cell_ctl_t;

endpackage

@@ src/tklt_cell.sv @@
module tklt_cell #(
    parameter int TW = 32
) (
    input  logic                        aclk,
    input  tklt_pkg::cell_ctl_t         ctl,
    input  logic [tklt_pkg::SIZE_W-1:0] new_size,
    input  logic [TW-1:0]               new_tag,
    input  logic [tklt_pkg::SIZE_W-1:0] prev_size,
    input  logic [TW-1:0]               prev_tag,
    output logic                        ge,
    output logic [tklt_pkg::SIZE_W-1:0] size_q,
    output logic [TW-1:0]               tag_q
);
    import tklt_pkg::*;

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [TW-1:0]     tag_reg, tag_next;

    // equal sizes keep their place ahead of the newcomer
    assign ge = ctl.valid && (size_reg >= new_size);

    always_comb begin
        size_next = size_reg;
        tag_next  = tag_reg;
        if (ctl.ins_en && !ge) begin
            if (ctl.prev_ge) begin
                size_next = new_size;
                tag_next  = new_tag;
            end else begin
                size_next = prev_size;
                tag_next  = prev_tag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        size_reg <= size_next;
        tag_reg  <= tag_next;
    end

    assign size_q = size_reg;
    assign tag_q  = tag_reg;

endmodule

@@ src/top_k_largest_tracker.sv @@
// Keeps the largest entries seen so far, sorted largest first, in a chain of cells, one entry
// per cell. An insert item is compared against every cell at once and the list shifts by one
// cell in the same clock, so an item of either kind is accepted every cycle unless the output
// stalls; its registered result reflects the list after that item. Ties place the new entry
// behind entries of equal size. keep_limit 0 acts as 1 and values above the cell count act as
// the cell count; lowering it drops the extra entries at once. The list is empty after reset
// and keep_limit resets to 16. Configuration must be written only while idle, not enforced.
module top_k_largest_tracker #(
    parameter int MAX_ENTRIES = 16,
    parameter int TAG_BITS    = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [4:0]   cfg_data,    // keep_limit
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,     // entry_size[63:0], entry_tag[95:64], read_rank[99:96]
    input  logic [0:0]   s_tuser,     // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata      // read_size[63:0], read_tag[95:64], read_valid[96],
                                      // entry_count[101:97], smallest_kept[165:102],
                                      // list_full[166]
);
    import tklt_pkg::*;

    // the limit cannot exceed 31, so cells beyond that never hold an entry
    localparam int CELLS = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;
    localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int TW    = (TAG_BITS < OTAG_W) ? TAG_BITS : OTAG_W;

    function automatic logic [CNT_W-1:0] eff_limit(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CNT_W'(CELLS)) begin
            r = CNT_W'(CELLS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [SIZE_W-1:0] in_size;
    logic [TW-1:0]     in_tag;
    logic [RANK_W-1:0] in_rank;
    logic              in_action;

    assign in_size   = s_tdata[63:0];
    assign in_tag    = s_tdata[64 +: TW];
    assign in_rank   = s_tdata[99:96];
    assign in_action = s_tuser[0];

    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pend_reg, pend_next;
    logic              pend_action_reg, pend_action_next;
    logic [RANK_W-1:0] pend_rank_reg, pend_rank_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [167:0]      m_tdata_reg, m_tdata_next;

    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  lim_m1;
    logic              out_free;
    logic              in_acc;
    logic              cfg_acc;
    logic              shift_en;
    logic [CELLS-1:0]  ge_vec;
    logic [SIZE_W-1:0] size_arr [CELLS];
    logic [TW-1:0]     tag_arr  [CELLS];

    assign lim      = eff_limit(limit_reg);
    assign lim_m1   = lim - CNT_W'(1);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !pend_reg || out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_acc  = cfg_valid;
    // an insert behind the last allowed rank is rejected
    assign shift_en = in_acc && (in_action == ACT_INSERT) && !ge_vec[lim_m1[IW-1:0]];

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        cell_ctl_t         ctl;
        logic [SIZE_W-1:0] p_size;
        logic [TW-1:0]     p_tag;

        if (i == 0) begin : g_head
            assign ctl.prev_ge = 1'b1;
            assign p_size      = in_size;
            assign p_tag       = in_tag;
        end else begin : g_body
            assign ctl.prev_ge = ge_vec[i-1];
            assign p_size      = size_arr[i-1];
            assign p_tag       = tag_arr[i-1];
        end
        assign ctl.ins_en = shift_en;
        assign ctl.valid  = CNT_W'(i) < count_reg;

        tklt_cell #(
            .TW(TW)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .new_size  (in_size),
            .new_tag   (in_tag),
            .prev_size (p_size),
            .prev_tag  (p_tag),
            .ge        (ge_vec[i]),
            .size_q    (size_arr[i]),
            .tag_q     (tag_arr[i])
        );
    end

    logic              rd_ok;
    logic [SIZE_W-1:0] rd_size;
    logic [OTAG_W-1:0] rd_tag;
    logic [SIZE_W-1:0] smallest;
    logic              full;
    logic [IW-1:0]     rd_idx;
    logic [IW-1:0]     last_idx;

    assign rd_idx   = IW'(pend_rank_reg);
    assign last_idx = IW'(count_reg - CNT_W'(1));
    assign rd_ok    = (pend_action_reg == ACT_READ) && ({1'b0, pend_rank_reg} < count_reg);
    assign rd_size  = rd_ok ? size_arr[rd_idx] : '0;
    assign rd_tag   = rd_ok ? OTAG_W'(tag_arr[rd_idx]) : '0;
    assign smallest = (count_reg != '0) ? size_arr[last_idx] : '0;
    assign full     = count_reg >= lim;

    always_comb begin
        limit_next       = limit_reg;
        count_next       = count_reg;
        pend_next        = pend_reg;
        pend_action_next = pend_action_reg;
        pend_rank_next   = pend_rank_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;

        if (cfg_acc) begin
            limit_next = cfg_data;
            if (count_reg > eff_limit(cfg_data)) begin
                count_next = eff_limit(cfg_data);
            end
        end else if (shift_en && (count_reg < lim)) begin
            count_next = count_reg + CNT_W'(1);
        end

        // result is taken from the cells after the item has changed them, once the output is free
        if (pend_reg && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, full, smallest, count_reg, rd_ok, rd_tag, rd_size};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (in_acc) begin
            pend_next        = 1'b1;
            pend_action_next = in_action;
            pend_rank_next   = in_rank;
        end else if (out_free) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= CNT_W'(16);
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            limit_reg    <= limit_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pend_action_reg <= pend_action_next;
        pend_rank_reg   <= pend_rank_next;
        m_tdata_reg     <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tklt_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        logic [SIZE_W-1:0] read_size;
        logic [OTAG_W-1:0] read_tag;
        logic              read_valid;
        logic [CNT_W-1:0]  entry_count;
        logic [SIZE_W-1:0] smallest_kept;
        logic              list_full;
    } tracker_result_t;

    class ranked_list_board;
        bit [SIZE_W-1:0]   sizes[LIST_DEPTH];
        bit [OTAG_W-1:0]   tags[LIST_DEPTH];
        int unsigned       held = 0;
        int unsigned       keep_limit = 16;
        tracker_result_t   due_results[$];
        int unsigned       fail_count = 0;
        int unsigned       checked = 0;
        int unsigned       inserts = 0;
        int unsigned       reads = 0;
        int unsigned       rejected = 0;
        int unsigned       hit_reads = 0;

        function int unsigned eff_limit();
            if (keep_limit == 0)
                return 1;
            if (keep_limit > LIST_DEPTH)
                return LIST_DEPTH;
            return keep_limit;
        endfunction

        function void write_limit(logic [CNT_W-1:0] value);
            keep_limit = 32'(value);
            if (held > eff_limit())
                held = eff_limit();
        endfunction

        // new entry lands behind every entry of equal or larger size
        function void place_entry(bit [SIZE_W-1:0] size, bit [OTAG_W-1:0] tag);
            int unsigned lim;
            int unsigned pos;
            int unsigned i;
            lim = eff_limit();
            pos = 0;
            while (pos < held && sizes[pos] >= size)
                pos++;
            if (pos >= lim) begin
                rejected++;
                return;
            end
            i = (held >= lim) ? lim - 1 : held;
            while (i > pos) begin
                sizes[i] = sizes[i-1];
                tags[i]  = tags[i-1];
                i--;
            end
            sizes[pos] = size;
            tags[pos]  = tag;
            if (held < lim)
                held++;
        endfunction

        function void note_item(logic act, logic [SIZE_W-1:0] size, logic [OTAG_W-1:0] tag,
                                logic [RANK_W-1:0] rank);
            tracker_result_t r;
            r.read_size  = '0;
            r.read_tag   = '0;
            r.read_valid = 1'b0;
            if (act == ACT_INSERT) begin
                inserts++;
                place_entry(size, tag);
            end else begin
                reads++;
                if (rank < held) begin
                    r.read_size  = sizes[rank];
                    r.read_tag   = tags[rank];
                    r.read_valid = 1'b1;
                    hit_reads++;
                end
            end
            r.entry_count   = held[CNT_W-1:0];
            r.smallest_kept = (held > 0) ? sizes[held-1] : '0;
            r.list_full     = (held >= eff_limit());
            due_results.push_back(r);
        endfunction

        function void compare_field(string fname, logic [SIZE_W-1:0] want,
                                    logic [SIZE_W-1:0] got);
            if (want !== got) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("mismatch on result %0d, %s: expected %0h, got %0h",
                             checked, fname, want, got);
            end
        endfunction

        function void check_result(logic [167:0] d);
            tracker_result_t want;
            if (due_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result %0h with nothing outstanding", d);
                return;
            end
            want = due_results.pop_front();
            compare_field("read_size", want.read_size, d[63:0]);
            compare_field("read_tag", 64'(want.read_tag), 64'(d[95:64]));
            compare_field("read_valid", 64'(want.read_valid), 64'(d[96]));
            compare_field("entry_count", 64'(want.entry_count), 64'(d[101:97]));
            compare_field("smallest_kept", want.smallest_kept, d[165:102]);
            compare_field("list_full", 64'(want.list_full), 64'(d[166]));
            checked++;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction
    endclass

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [4:0]     cfg_data = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [103:0]   s_tdata = '0;
    logic [0:0]     s_tuser = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [167:0]   m_tdata;

    ranked_list_board board = new;
    bit             tx_idle_on = 1'b1;
    bit             rx_idle_on = 1'b1;
    bit             hold_pending = 1'b0;
    int unsigned    cycle_count = 0;
    int unsigned    limit_writes = 0;

    top_k_largest_tracker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending());
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // result side: random stalls, plus one long hold-off so the list backs up
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_pending) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_pending = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic act, input logic [SIZE_W-1:0] size,
                             input logic [OTAG_W-1:0] tag, input logic [RANK_W-1:0] rank);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0000, rank, tag, size};
        do
            @(posedge aclk);
        while (!s_tready);
        board.note_item(act, size, tag, rank);
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [4:0] value);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        board.write_limit(value);
        limit_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return {$urandom, $urandom};
            4: return 64'($urandom_range(0, 63));
            5: return {32'd0, $urandom};
            6: return {$urandom, 32'd0};
            default: return ~64'($urandom_range(0, 255));
        endcase
    endfunction

    // narrow sizes make ties common and keep small entries competitive
    task automatic send_random(input int n, input bit narrow);
        logic              act;
        logic [SIZE_W-1:0] size;
        for (int k = 0; k < n; k++) begin
            act  = ($urandom_range(0, 9) < 6) ? ACT_INSERT : ACT_READ;
            size = narrow ? 64'($urandom_range(0, 63)) : pick_size();
            send_item(act, size, $urandom, RANK_W'($urandom_range(0, 15)));
        end
        end_burst();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty list reads, extremes, ties, reads at and past the count
        send_item(ACT_READ, '1, '1, 4'd0);
        send_item(ACT_READ, '0, '0, 4'd15);
        send_item(ACT_INSERT, '0, '0, '1);
        send_item(ACT_INSERT, '1, '1, '0);
        send_item(ACT_INSERT, 64'd1000, 32'h0000_000a, 4'd3);
        send_item(ACT_INSERT, 64'd1000, 32'h0000_000b, 4'd7);
        send_item(ACT_INSERT, 64'd1000, 32'h0000_000c, 4'd9);
        send_item(ACT_INSERT, '0, 32'h0000_0005, 4'd1);
        for (int r = 0; r < 4; r++)
            send_item(ACT_READ, {$urandom, $urandom}, $urandom, RANK_W'(r));
        send_item(ACT_READ, '0, '0, 4'd5);
        send_item(ACT_READ, '0, '0, 4'd6);
        send_item(ACT_READ, '1, '1, 4'd15);
        end_burst();

        // lowering the limit drops entries; a full list rejects smaller and equal sizes
        write_limit(5'd1);
        send_item(ACT_INSERT, 64'd5, 32'h1234_5678, 4'd0);
        send_item(ACT_INSERT, '1, 32'hdead_0001, 4'd0);
        send_item(ACT_READ, '0, '0, 4'd0);
        send_item(ACT_READ, '0, '0, 4'd1);
        end_burst();

        write_limit(5'd0);
        send_item(ACT_INSERT, 64'd7, 32'h0000_0007, 4'd0);
        send_item(ACT_READ, '0, '0, 4'd0);
        end_burst();

        write_limit(5'd31);
        send_random(130, 1'b1);
        write_limit(5'd3);
        send_random(90, 1'b0);
        write_limit(5'd17);
        hold_pending = 1'b1;
        send_random(130, 1'b0);
        write_limit(5'd8);
        send_random(110, 1'b1);
        write_limit(5'd2);
        send_random(80, 1'b1);
        write_limit(5'd12);
        send_random(120, 1'b0);

        write_limit(5'd16);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random(140, 1'b0);

        drain();
        $display("covered %0d inserts (%0d turned away) and %0d reads (%0d hit an entry)",
                 board.inserts, board.rejected, board.reads, board.hit_reads);
        $display("%0d results checked over %0d keep_limit writes", board.checked,
                 limit_writes);
        if (board.fail_count == 0 && board.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("%0d failures, %0d results still outstanding", board.fail_count,
                     board.pending());
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/tklt_pkg.sv
src/tklt_cell.sv
src/top_k_largest_tracker.sv
tb/sv/testbench.sv
